// ===== design/lpr_pkg.sv =====
// lpr_pkg: shared types, constants and helpers for the LRU page replacement block.
// No dependencies; imported by lpr_cell and lru_page_replacement.
package lpr_pkg;

	localparam int FRAME_SLOTS = 16;
	localparam int PAGE_BITS   = 20;
	localparam int IDX_W       = $clog2(FRAME_SLOTS);
	localparam int RANK_W      = $clog2(FRAME_SLOTS);
	localparam int CFG_W       = $clog2(FRAME_SLOTS) + 1;
	localparam int CNT_W       = 32;
	localparam int IN_DATA_W   = ((PAGE_BITS + 7) / 8) * 8;
	localparam int OUT_FIELD_W = 1 + IDX_W + 1 + PAGE_BITS + CNT_W + CNT_W;
	localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(4);

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [RANK_W-1:0]    rank_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	// Broadcast from the control to every cell
	typedef struct packed {
		logic  upd;
		logic  fill_all;
		rank_t limit;
		page_t page;
	} lpr_bcast_t;

	// Priority chain passed from cell j to cell j+1
	typedef struct packed {
		logic hit_seen;
		logic empty_seen;
	} lpr_chain_t;

	// Per-cell status back to the control
	typedef struct packed {
		logic  hit_first;
		logic  empty_first;
		logic  valid;
		rank_t rank;
	} lpr_stat_t;

	function automatic idx_t onehot_to_idx(input logic [FRAME_SLOTS-1:0] oh);
		idx_t idx;
		idx = '0;
		for (int j = 0; j < FRAME_SLOTS; j++) begin
			if (oh[j]) begin
				idx = idx | idx_t'(j);
			end
		end
		return idx;
	endfunction

	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == '1) ? v : v + cnt_t'(1);
	endfunction

endpackage

// ===== design/lpr_cell.sv =====
// lpr_cell: one page frame (page, valid, recency rank) with its compare logic.
// Depends on lpr_pkg; chained in a row by lru_page_replacement.
module lpr_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  lpr_pkg::lpr_bcast_t bcast,
	input  logic               active,
	input  logic               is_target,
	input  logic               write_page,
	input  lpr_pkg::lpr_chain_t chain_in,
	output lpr_pkg::lpr_chain_t chain_out,
	output lpr_pkg::lpr_stat_t  stat,
	output lpr_pkg::page_t      page
);
	import lpr_pkg::*;

	page_t page_q;
	logic  valid_q;
	rank_t rank_q;
	logic  match;
	logic  empty;

	assign match = active && valid_q && (page_q == bcast.page);
	assign empty = active && !valid_q;

	assign chain_out.hit_seen   = chain_in.hit_seen | match;
	assign chain_out.empty_seen = chain_in.empty_seen | empty;

	assign stat.hit_first   = match && !chain_in.hit_seen;
	assign stat.empty_first = empty && !chain_in.empty_seen;
	assign stat.valid       = valid_q;
	assign stat.rank        = rank_q;
	assign page             = page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (bcast.upd) begin
			if (is_target) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else if (valid_q && (bcast.fill_all || rank_q < bcast.limit)) begin
				rank_q <= rank_q + rank_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bcast.upd && write_page && is_target) begin
			page_q <= bcast.page;
		end
	end

endmodule

// ===== design/lru_page_replacement.sv =====
// lru_page_replacement: fully associative page frame table, LRU replacement.
// Depends on lpr_pkg and lpr_cell.
//
// Each beat on s_tdata is one page reference; one result beat per reference
// comes out on m_tdata, with m_tvalid raised from the output register after the
// reference has passed the input register. One reference is taken per cycle while
// result beats are taken: the row of frame cells compares and picks the frame
// combinationally and updates page, valid and rank at the same clock edge,
// and the priority chain through the row of cells sets the cycle time. The input
// register holds a reference while the output register is full and not taken.
// cfg_data sets how many frames (from frame 0) take part; 0 acts as 1, values
// above the frame count act as the frame count. Hit and fault counts saturate.
module lru_page_replacement (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lpr_pkg::IN_DATA_W-1:0]   s_tdata,  // page_number
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// hit, frame_index, evicted_valid, evicted_page, hits_total, faults_total
	output logic [lpr_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lpr_pkg::CFG_W-1:0]       cfg_data
);
	import lpr_pkg::*;

	logic [CFG_W-1:0]       frames_q;
	logic [CFG_W-1:0]       n_eff;
	logic                   s1_valid_q;
	page_t                  page_s1;
	logic                   proc;

	lpr_bcast_t             bcast;
	lpr_chain_t             chain [FRAME_SLOTS+1];
	lpr_stat_t              stat  [FRAME_SLOTS];
	page_t                  cell_page [FRAME_SLOTS];
	logic [FRAME_SLOTS-1:0] active;
	logic [FRAME_SLOTS-1:0] hit_vec;
	logic [FRAME_SLOTS-1:0] empty_vec;
	logic [FRAME_SLOTS-1:0] victim_vec;
	logic [FRAME_SLOTS-1:0] target;
	logic                   any_hit;
	logic                   any_empty;
	logic                   evict;
	rank_t                  limit;
	page_t                  old_page;

	cnt_t                   hits_q;
	cnt_t                   faults_q;
	cnt_t                   hits_nxt;
	cnt_t                   faults_nxt;

	logic                   out_valid_q;
	logic                   out_hit_q;
	idx_t                   out_idx_q;
	logic                   out_ev_q;
	page_t                  out_old_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
		end else if (cfg_valid) begin
			frames_q <= cfg_data;
		end
	end

	always_comb begin
		if (frames_q == '0) begin
			n_eff = CFG_W'(1);
		end else if (frames_q > CFG_W'(FRAME_SLOTS)) begin
			n_eff = CFG_W'(FRAME_SLOTS);
		end else begin
			n_eff = frames_q;
		end
	end

	// input register
	assign proc     = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			page_s1 <= s_tdata[PAGE_BITS-1:0];
		end
	end

	// row of frame cells
	assign chain[0] = '0;

	for (genvar j = 0; j < FRAME_SLOTS; j++) begin : g_cell
		assign active[j]    = CFG_W'(j) < n_eff;
		assign hit_vec[j]   = stat[j].hit_first;
		assign empty_vec[j] = stat[j].empty_first;

		lpr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.bcast      (bcast),
			.active     (active[j]),
			.is_target  (target[j]),
			.write_page (!any_hit),
			.chain_in   (chain[j]),
			.chain_out  (chain[j+1]),
			.stat       (stat[j]),
			.page       (cell_page[j])
		);
	end

	assign any_hit   = chain[FRAME_SLOTS].hit_seen;
	assign any_empty = chain[FRAME_SLOTS].empty_seen;
	assign evict     = !any_hit && !any_empty;

	// victim: active valid frame that no other active valid frame outranks
	always_comb begin
		logic gt;
		for (int j = 0; j < FRAME_SLOTS; j++) begin
			gt = 1'b0;
			for (int k = 0; k < FRAME_SLOTS; k++) begin
				if (active[k] && stat[k].valid && (stat[k].rank > stat[j].rank)) begin
					gt = 1'b1;
				end
			end
			victim_vec[j] = active[j] && stat[j].valid && !gt;
		end
	end

	always_comb begin
		if (any_hit) begin
			target = hit_vec;
		end else if (any_empty) begin
			target = empty_vec;
		end else begin
			target = victim_vec;
		end
	end

	always_comb begin
		limit    = '0;
		old_page = '0;
		for (int j = 0; j < FRAME_SLOTS; j++) begin
			if (target[j]) begin
				limit    = limit | stat[j].rank;
				old_page = old_page | cell_page[j];
			end
		end
	end

	assign bcast.upd      = proc;
	assign bcast.fill_all = !any_hit && any_empty;
	assign bcast.limit    = limit;
	assign bcast.page     = page_s1;

	// counters
	assign hits_nxt   = any_hit ? sat_inc(hits_q) : hits_q;
	assign faults_nxt = any_hit ? faults_q : sat_inc(faults_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q   <= '0;
			faults_q <= '0;
		end else if (proc) begin
			hits_q   <= hits_nxt;
			faults_q <= faults_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			out_hit_q <= any_hit;
			out_idx_q <= onehot_to_idx(target);
			out_ev_q  <= evict;
			out_old_q <= evict ? old_page : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_DATA_W'({faults_q, hits_q, out_old_q, out_ev_q, out_idx_q, out_hit_q});

`ifndef ASSERT_OFF
	a_target_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		proc |-> $onehot(target))
		else $error("frame selection is not one-hot");

	a_victim_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && evict) |-> $onehot(victim_vec))
		else $error("no unique LRU victim among active frames");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		proc |=> m_tvalid)
		else $error("processed reference produced no result beat");

	a_faults_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> (faults_q >= $past(faults_q)) && (hits_q >= $past(hits_q)))
		else $error("counter went backwards");
`endif

endmodule

// ===== sim/tb_lru_page_replacement.sv =====
// tb_lru_page_replacement: self-checking bench for the LRU page frame table, with
// directed references, then random references drawn mostly from a small page pool across frame counts.
// Depends on lpr_pkg and lru_page_replacement.
module tb_lru_page_replacement;
	timeunit 1ns;
	timeprecision 1ps;

	import lpr_pkg::*;

	localparam int POOL_SIZE  = 24;
	localparam int STUCK_MAX  = 2000;

	// fields from the lowest bit up: hit, frame_index, evicted_valid, evicted_page,
	// hits_total, faults_total
	typedef struct packed {
		cnt_t  faults_total;
		cnt_t  hits_total;
		page_t evicted_page;
		logic  evicted_valid;
		idx_t  frame_index;
		logic  hit;
	} page_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // page_number
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;       // see page_result_t
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_W-1:0]      cfg_data = '0;

	// mirror of the frame table
	page_t            frm_page [FRAME_SLOTS];
	logic             frm_valid[FRAME_SLOTS];
	rank_t            frm_rank [FRAME_SLOTS];
	cnt_t             hit_cnt;
	cnt_t             fault_cnt;
	logic [CFG_W-1:0] frames_cfg;

	page_t        page_refs_q[$];
	page_result_t expected_results_q[$];
	page_t        ref_pool[POOL_SIZE];
	int           phase_frames[12];

	int unsigned tx_gap;
	int unsigned rx_wait;
	bit          tx_calm;
	bit          rx_calm;
	int          mismatch_count = 0;
	int          stuck_cycles = 0;

	lru_page_replacement uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// age valid frames ranked below limit, target becomes most recent
	function automatic void make_newest(int tgt, int limit);
		for (int j = 0; j < FRAME_SLOTS; j++) begin
			if (j != tgt && frm_valid[j] && int'(frm_rank[j]) < limit) begin
				frm_rank[j] = frm_rank[j] + rank_t'(1);
			end
		end
		frm_rank[tgt] = '0;
	endfunction

	function automatic page_result_t resolve_reference(page_t pg);
		int           n;
		int           tgt;
		logic         found;
		logic         empty;
		page_result_t r;
		n = (frames_cfg == 0) ? 1 : (frames_cfg > FRAME_SLOTS) ? FRAME_SLOTS : int'(frames_cfg);
		r = '0;
		found = 1'b0;
		empty = 1'b0;
		tgt = 0;
		for (int j = 0; j < n; j++) begin
			if (!found && frm_valid[j] && frm_page[j] == pg) begin
				tgt = j;
				found = 1'b1;
			end
		end
		if (found) begin
			make_newest(tgt, int'(frm_rank[tgt]));
			hit_cnt = (hit_cnt == '1) ? hit_cnt : hit_cnt + cnt_t'(1);
		end else begin
			for (int j = 0; j < n; j++) begin
				if (!empty && !frm_valid[j]) begin
					tgt = j;
					empty = 1'b1;
				end
			end
			if (empty) begin
				frm_valid[tgt] = 1'b1;
				make_newest(tgt, FRAME_SLOTS + 1);
			end else begin
				tgt = 0;
				for (int j = 1; j < n; j++) begin
					if (frm_rank[j] > frm_rank[tgt]) begin
						tgt = j;
					end
				end
				r.evicted_valid = 1'b1;
				r.evicted_page  = frm_page[tgt];
				make_newest(tgt, int'(frm_rank[tgt]));
			end
			frm_page[tgt] = pg;
			fault_cnt = (fault_cnt == '1) ? fault_cnt : fault_cnt + cnt_t'(1);
		end
		r.hit          = found;
		r.frame_index  = idx_t'(tgt);
		r.hits_total   = hit_cnt;
		r.faults_total = fault_cnt;
		return r;
	endfunction

	function automatic page_t draw_page(int n);
		int    pick;
		page_t p;
		pick = $urandom_range(0, 99);
		if (pick < 82) begin
			p = ref_pool[$urandom_range(0, ((n + 4) > POOL_SIZE ? POOL_SIZE : n + 4) - 1)];
		end else if (pick < 97) begin
			p = page_t'($urandom());
		end else begin
			p = page_t'(1) << $urandom_range(0, PAGE_BITS - 1);
			if ($urandom_range(0, 1) == 1) begin
				p = ~p;
			end
		end
		return p;
	endfunction

	// driver: one beat per queued reference, random gap after each
	always @(posedge clk or negedge arst_n) begin : drive
		int unsigned gap;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			tx_gap <= 0;
		end else begin
			gap = tx_gap;
			if (s_tvalid && s_tready) begin
				expected_results_q.push_back(resolve_reference(s_tdata[PAGE_BITS-1:0]));
				if ($urandom_range(0, 49) == 0) begin
					tx_calm = !tx_calm;
				end
				gap = tx_calm ? 0 : $urandom_range(0, 4);
			end
			if (!s_tvalid || s_tready) begin
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					tx_gap <= gap - 1;
				end else if (page_refs_q.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= IN_DATA_W'(page_refs_q.pop_front());
					tx_gap <= 0;
				end else begin
					s_tvalid <= 1'b0;
					tx_gap <= 0;
				end
			end
		end
	end

	// monitor: checks each result beat against the oldest expectation
	always @(posedge clk or negedge arst_n) begin : observe
		int unsigned  wait_n;
		logic         bad;
		page_result_t got;
		page_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait <= 0;
		end else begin
			wait_n = rx_wait;
			if (m_tvalid && m_tready) begin
				got = page_result_t'(m_tdata[OUT_FIELD_W-1:0]);
				if (expected_results_q.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, got %h", $time, m_tdata);
					mismatch_count++;
				end else begin
					want = expected_results_q.pop_front();
					bad = 1'b0;
					if (got.hit !== want.hit) begin
						$display("%0t: hit expected %0d got %0d", $time, want.hit, got.hit);
						bad = 1'b1;
					end
					if (got.frame_index !== want.frame_index) begin
						$display("%0t: frame_index expected %0d got %0d", $time,
							want.frame_index, got.frame_index);
						bad = 1'b1;
					end
					if (got.evicted_valid !== want.evicted_valid) begin
						$display("%0t: evicted_valid expected %0d got %0d", $time,
							want.evicted_valid, got.evicted_valid);
						bad = 1'b1;
					end
					if (got.evicted_page !== want.evicted_page) begin
						$display("%0t: evicted_page expected %h got %h", $time,
							want.evicted_page, got.evicted_page);
						bad = 1'b1;
					end
					if (got.hits_total !== want.hits_total) begin
						$display("%0t: hits_total expected %0d got %0d", $time,
							want.hits_total, got.hits_total);
						bad = 1'b1;
					end
					if (got.faults_total !== want.faults_total) begin
						$display("%0t: faults_total expected %0d got %0d", $time,
							want.faults_total, got.faults_total);
						bad = 1'b1;
					end
					if (m_tdata[OUT_DATA_W-1:OUT_FIELD_W] !== '0) begin
						$display("%0t: pad bits expected 0 got %h", $time,
							m_tdata[OUT_DATA_W-1:OUT_FIELD_W]);
						bad = 1'b1;
					end
					if (bad) begin
						mismatch_count++;
					end
				end
				if ($urandom_range(0, 49) == 0) begin
					rx_calm = !rx_calm;
				end
				wait_n = rx_calm ? 0 : $urandom_range(0, 4);
			end
			if (wait_n != 0) begin
				m_tready <= 1'b0;
				rx_wait <= wait_n - 1;
			end else begin
				m_tready <= 1'b1;
				rx_wait <= 0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles == STUCK_MAX) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// hold off until every queued reference has been sent and answered
	task automatic wait_quiet();
		do @(negedge clk);
		while (page_refs_q.size() != 0 || s_tvalid || expected_results_q.size() != 0);
	endtask

	task automatic set_frames(input logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		frames_cfg = v;
	endtask

	initial begin
		int    cnt;
		page_t p2;
		page_t p3;
		frames_cfg = FRAMES_RESET;
		hit_cnt = '0;
		fault_cnt = '0;
		for (int j = 0; j < FRAME_SLOTS; j++) begin
			frm_page[j] = '0;
			frm_valid[j] = 1'b0;
			frm_rank[j] = '0;
		end
		ref_pool[0] = '0;
		ref_pool[1] = '1;
		for (int j = 2; j < POOL_SIZE; j++) begin
			ref_pool[j] = page_t'($urandom());
		end
		phase_frames = '{16, 1, 31, 0, 6, 3, 16, 20, 2, 9, 4, 16};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset frame count: fills, hits, then LRU evictions
		page_refs_q = '{20'h00000, 20'hFFFFF, 20'hFFFFF, 20'h12345, 20'hABCDE,
			20'h00000, 20'h55555, 20'hAAAAA, 20'hFFFFF, 20'h12345};
		wait_quiet();
		p2 = frm_page[2];
		p3 = frm_page[3];

		// lowered: frames 2 and 3 drop out, their pages get refilled below
		set_frames(CFG_W'(2));
		page_refs_q = '{p2, p3, p2};
		wait_quiet();

		// raised: same pages now resident twice, lowest frame must hit
		set_frames(CFG_W'(16));
		page_refs_q = '{p2, p3, 20'h0F0F0, 20'h0F0F0};
		wait_quiet();

		set_frames(CFG_W'(0));
		page_refs_q = '{20'h0F0F0, 20'h33333};
		wait_quiet();

		set_frames(CFG_W'(31));
		page_refs_q = '{p3, 20'h33333};
		wait_quiet();

		foreach (phase_frames[k]) begin
			set_frames(CFG_W'(phase_frames[k]));
			repeat (4) ref_pool[$urandom_range(2, POOL_SIZE - 1)] = page_t'($urandom());
			cnt = $urandom_range(120, 180);
			for (int i = 0; i < cnt; i++) begin
				page_refs_q.push_back(draw_page(phase_frames[k] == 0 ? 1 :
					(phase_frames[k] > FRAME_SLOTS ? FRAME_SLOTS : phase_frames[k])));
			end
			wait_quiet();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_results_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== lru_page_replacement.f =====
design/lpr_pkg.sv
design/lpr_cell.sv
design/lru_page_replacement.sv
sim/tb_lru_page_replacement.sv
